// ----- design/assert_macros.svh -----
// concurrent assertion helpers, sampled on clock and muted during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mlr_pkg.sv -----
package mlr_pkg;

   // width of every coordinate field on the ports
   localparam int COORD_W = 6;

   // default number of coordinate bits in use, at most COORD_W
   localparam int COORD_BITS_DEF = 6;

   // entries in the command queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // one line command
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } mlr_req_type;

   // one pixel of a line
   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               last_pixel;
   } mlr_rsp_type;

endpackage

// ----- design/midpoint_line_rasterizer.sv -----
// an accepted line is queued, then loaded into the stepper registers, which show its first pixel
// throughput: one pixel per cycle; a line has max(|dx|,|dy|)+1 pixels, up to 2^COORD_BITS
// queued lines follow each other with no gap; the pixel stepper sets the pace
// busy rises while the two-entry command queue is full; results cannot be stalled
// reset (synchronous) empties the queue and drops any line in progress
module midpoint_line_rasterizer #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mlr_pkg::mlr_req_type req_cmd,
   output logic                 rsp_valid,
   output mlr_pkg::mlr_rsp_type rsp_pixel
);
   import mlr_pkg::*;

   localparam int CMD_W = 5 * COORD_BITS + 4;

   logic             push, full, not_empty, pop;
   logic [CMD_W-1:0] front_cmd, queued_cmd;

   assign push = start && !full;
   assign busy = full;

   // classify and order endpoints
   mlr_front #(
      .COORD_BITS (COORD_BITS),
      .CMD_W      (CMD_W)
   ) u_front (
      .req_cmd  (req_cmd),
      .cmd_data (front_cmd)
   );

   // decouple classification from stepping
   mlr_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (full),
      .not_empty (not_empty),
      .pop       (pop),
      .pop_data  (queued_cmd)
   );

   // step pixels along the line
   mlr_back #(
      .COORD_BITS (COORD_BITS),
      .CMD_W      (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (not_empty),
      .cmd_data  (queued_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_pixel)
   );

endmodule

// ----- design/mlr_front.sv -----
module mlr_front #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
   parameter int CMD_W      = 5 * COORD_BITS + 4
) (
   input  mlr_pkg::mlr_req_type req_cmd,
   output logic [CMD_W-1:0]     cmd_data
);
   import mlr_pkg::*;

   logic [COORD_BITS-1:0]   ax, ay, bx, by;
   logic                    swap;
   logic [COORD_BITS-1:0]   x0, y0, x1, y1;
   logic [COORD_BITS-1:0]   dx, ady, dmaj, dmin;
   logic signed [COORD_BITS:0] dy;
   logic                    sy_neg, steep;
   logic signed [COORD_BITS+1:0] d0;

   // keep only the coordinate bits in use
   assign ax = req_cmd.start_x[COORD_BITS-1:0];
   assign ay = req_cmd.start_y[COORD_BITS-1:0];
   assign bx = req_cmd.end_x[COORD_BITS-1:0];
   assign by = req_cmd.end_y[COORD_BITS-1:0];

   // order endpoints: left to right, vertical lines bottom to top
   assign swap = (bx < ax) || ((bx == ax) && (by < ay));
   assign x0   = swap ? bx : ax;
   assign y0   = swap ? by : ay;
   assign x1   = swap ? ax : bx;
   assign y1   = swap ? ay : by;

   // deltas and octant class
   assign dx     = x1 - x0;
   assign dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});
   assign sy_neg = dy[COORD_BITS];
   assign ady    = sy_neg ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
   assign steep  = ady > dx;
   assign dmaj   = steep ? ady : dx;
   assign dmin   = steep ? dx : ady;

   // initial decision value 2*minor - major
   assign d0 = $signed({1'b0, dmin, 1'b0}) - $signed({2'b00, dmaj});

   assign cmd_data = {x0, y0, dmaj, dmin, d0, steep, sy_neg};

endmodule

// ----- design/mlr_queue.sv -----
module mlr_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = mlr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              not_empty,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data
);
   import mlr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue fill count over depth")
   `ASSERT_IMPLIES(a_pop_nonempty, pop, count_ff != '0, "pop from empty command queue")
   `ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

// ----- design/mlr_back.sv -----
module mlr_back #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
   parameter int CMD_W      = 5 * COORD_BITS + 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  logic [CMD_W-1:0]     cmd_data,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   output mlr_pkg::mlr_rsp_type rsp_pixel
);
   import mlr_pkg::*;

   localparam int DW = COORD_BITS + 2;

   // unpacked command fields
   logic [COORD_BITS-1:0] c_x0, c_y0, c_dmaj, c_dmin;
   logic signed [DW-1:0]  c_d0;
   logic                  c_steep, c_sy_neg;

   logic                  active_ff, active_in;
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [COORD_BITS-1:0] count_ff, count_in;
   logic [COORD_BITS-1:0] dmaj_ff, dmaj_in, dmin_ff, dmin_in;
   logic signed [DW-1:0]  d_ff, d_in;
   logic                  steep_ff, steep_in, sy_neg_ff, sy_neg_in;

   logic                  last, load, hold_minor;
   logic signed [DW-1:0]  inc_keep, inc_move;
   logic [COORD_BITS-1:0] x_step, y_step;

   assign {c_x0, c_y0, c_dmaj, c_dmin, c_d0, c_steep, c_sy_neg} = cmd_data;

   assign last    = count_ff == '0;
   assign load    = cmd_valid && (!active_ff || last);
   assign cmd_pop = load;

   // midpoint decision and increments
   assign hold_minor = d_ff <= 0;
   assign inc_keep   = $signed({1'b0, dmin_ff, 1'b0});
   assign inc_move   = $signed({1'b0, dmin_ff, 1'b0}) - $signed({1'b0, dmaj_ff, 1'b0});
   assign x_step     = x_ff + 1'b1;
   assign y_step     = sy_neg_ff ? y_ff - 1'b1 : y_ff + 1'b1;

   // stepper next state
   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      count_in  = count_ff;
      dmaj_in   = dmaj_ff;
      dmin_in   = dmin_ff;
      d_in      = d_ff;
      steep_in  = steep_ff;
      sy_neg_in = sy_neg_ff;
      if (load) begin
         active_in = 1'b1;
         x_in      = c_x0;
         y_in      = c_y0;
         count_in  = c_dmaj;
         dmaj_in   = c_dmaj;
         dmin_in   = c_dmin;
         d_in      = c_d0;
         steep_in  = c_steep;
         sy_neg_in = c_sy_neg;
      end else if (active_ff && last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         count_in = count_ff - 1'b1;
         d_in     = d_ff + (hold_minor ? inc_keep : inc_move);
         if (steep_ff) begin
            y_in = y_step;
            if (!hold_minor) begin
               x_in = x_step;
            end
         end else begin
            x_in = x_step;
            if (!hold_minor) begin
               y_in = y_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      count_ff  <= count_in;
      dmaj_ff   <= dmaj_in;
      dmin_ff   <= dmin_in;
      d_ff      <= d_in;
      steep_ff  <= steep_in;
      sy_neg_ff <= sy_neg_in;
   end

   // current pixel straight from the stepper registers
   assign rsp_valid            = active_ff;
   assign rsp_pixel.pixel_x    = COORD_W'(x_ff);
   assign rsp_pixel.pixel_y    = COORD_W'(y_ff);
   assign rsp_pixel.last_pixel = active_ff && last;

`include "assert_macros.svh"

   `ASSERT_NEXT(a_line_continues, active_ff && !last, active_ff, "line ended before last pixel")
   `ASSERT_NEXT(a_major_x_step, active_ff && !last && !steep_ff, x_ff == COORD_BITS'($past(x_ff) + 1'b1), "x did not advance")
   `ASSERT_NEXT(a_count_down, active_ff && !last, count_ff == COORD_BITS'($past(count_ff) - 1'b1), "pixel count skipped")

endmodule

// ----- tb/mlr_line_checker.sv -----
module mlr_line_checker #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  mlr_pkg::mlr_req_type req_cmd,
   input  logic                 rsp_valid,
   input  mlr_pkg::mlr_rsp_type rsp_pixel,
   output int                   pending_pixels,
   output int                   error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import mlr_pkg::*;

   localparam int COORD_SPAN = 1 << COORD_BITS;

   mlr_rsp_type expected_pixels[$];
   int          errors = 0;
   int          pixels_seen = 0;

   // queue one predicted pixel
   function automatic void push_pixel(input int x, input int y, input bit last);
      mlr_rsp_type px;
      px.pixel_x    = x[COORD_W-1:0];
      px.pixel_y    = y[COORD_W-1:0];
      px.last_pixel = last;
      expected_pixels.push_back(px);
   endfunction

   // midpoint line walk, one pixel per step
   function automatic void plot_line(input mlr_req_type cmd);
      int x0, y0, x1, y1, t;
      int dx, dy, ady, sy, d, x, y, n;
      x0 = int'(cmd.start_x) % COORD_SPAN;
      y0 = int'(cmd.start_y) % COORD_SPAN;
      x1 = int'(cmd.end_x) % COORD_SPAN;
      y1 = int'(cmd.end_y) % COORD_SPAN;

      // vertical lines go from the lower y upward
      if (x0 == x1) begin
         y = (y0 < y1) ? y0 : y1;
         n = ((y0 < y1) ? y1 : y0) - y + 1;
         for (int i = 0; i < n; i++)
            push_pixel(x0, y + i, i == n - 1);
         return;
      end

      // everything else runs left to right
      if (x1 < x0) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end

      dx  = x1 - x0;
      dy  = y1 - y0;
      sy  = (dy < 0) ? -1 : 1;
      ady = (dy < 0) ? -dy : dy;
      x   = x0;
      y   = y0;

      if (ady <= dx) begin
         // x-major, a tie keeps y
         d = 2 * ady - dx;
         for (int i = 0; i <= dx; i++) begin
            push_pixel(x, y, i == dx);
            if (d <= 0) begin
               d += 2 * ady;
            end else begin
               y += sy;
               d += 2 * (ady - dx);
            end
            x++;
         end
      end else begin
         // y-major, a tie keeps x
         d = 2 * dx - ady;
         for (int i = 0; i <= ady; i++) begin
            push_pixel(x, y, i == ady);
            if (d <= 0) begin
               d += 2 * dx;
            end else begin
               x++;
               d += 2 * (dx - ady);
            end
            y += sy;
         end
      end
   endfunction

   // log a bad pixel, only the first few in full
   function automatic void flag_pixel(input string what, input mlr_rsp_type want,
                                      input mlr_rsp_type got);
      errors++;
      if (errors <= 10)
         $display("%t pixel %0d %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                  $realtime, pixels_seen, what, want.pixel_x, want.pixel_y, want.last_pixel,
                  got.pixel_x, got.pixel_y, got.last_pixel);
   endfunction

   // compare pixels against the oldest prediction, then predict new items
   always @(posedge clock) begin
      mlr_rsp_type want;
      if (reset) begin
         expected_pixels.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               flag_pixel("unexpected", '0, rsp_pixel);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel.pixel_x !== want.pixel_x || rsp_pixel.pixel_y !== want.pixel_y ||
                   rsp_pixel.last_pixel !== want.last_pixel)
                  flag_pixel("wrong", want, rsp_pixel);
            end
            pixels_seen++;
         end
         if (start === 1'b1 && busy === 1'b0)
            plot_line(req_cmd);
      end
      pending_pixels <= expected_pixels.size();
      error_count    <= errors;
   end

endmodule

// ----- tb/tb_midpoint_line_rasterizer.sv -----
module tb_midpoint_line_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   import mlr_pkg::*;

   localparam int RANDOM_LINES = 480;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int COORD_MAX    = (1 << COORD_BITS_DEF) - 1;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   mlr_req_type req_cmd = '0;
   logic        busy;
   logic        rsp_valid;
   mlr_rsp_type rsp_pixel;
   int          pending_pixels;
   int          error_count;
   int          cycle_count = 0;

   // endpoints of the directed lines: start x, start y, end x, end y
   int directed_lines[22][4] = '{
      '{0, 0, 0, 0},      // single point at the origin
      '{63, 63, 63, 63},  // single point at the far corner
      '{0, 0, 63, 0},     // full horizontal
      '{63, 5, 0, 5},     // horizontal, right to left
      '{10, 0, 10, 63},   // full vertical upward
      '{40, 63, 40, 0},   // vertical given top first
      '{0, 0, 63, 63},    // diagonal
      '{63, 63, 0, 0},
      '{0, 63, 63, 0},    // falling diagonal
      '{63, 0, 0, 63},
      '{0, 0, 63, 1},     // shallowest slope
      '{0, 0, 1, 63},     // steepest slope
      '{5, 5, 7, 6},      // x-major tie
      '{5, 5, 6, 7},      // y-major tie
      '{20, 30, 12, 26},  // gentle, swapped
      '{20, 30, 29, 25},  // gentle, falling
      '{30, 10, 27, 40},  // steep, swapped
      '{3, 50, 9, 20},    // steep, falling
      '{42, 21, 21, 42},  // alternating bit patterns
      '{21, 42, 42, 21},
      '{63, 0, 0, 0},     // horizontal along the bottom edge
      '{0, 32, 1, 33}     // two-pixel diagonal
   };

   midpoint_line_rasterizer u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_pixel)
   );

   mlr_line_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_pixel      (rsp_pixel),
      .pending_pixels (pending_pixels),
      .error_count    (error_count)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic mlr_req_type line_cmd(input int sx, input int sy, input int ex,
                                            input int ey);
      mlr_req_type cmd;
      cmd.start_x = sx[COORD_W-1:0];
      cmd.start_y = sy[COORD_W-1:0];
      cmd.end_x   = ex[COORD_W-1:0];
      cmd.end_y   = ey[COORD_W-1:0];
      return cmd;
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // present one item after an idle gap and hold it until taken
   task automatic send_line(input mlr_req_type cmd, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start   <= 1'b1;
      req_cmd <= cmd;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // stop sending until every predicted pixel is out
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
   endtask

   // stimulus and verdict
   initial begin
      int sx, sy, ex, ey;
      int mode, gap, phase, dxs, dys, reach;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      foreach (directed_lines[i])
         send_line(line_cmd(directed_lines[i][0], directed_lines[i][1],
                            directed_lines[i][2], directed_lines[i][3]),
                   $urandom_range(0, 15));
      wait_for_drain();

      // random lines of mixed shapes
      for (int i = 0; i < RANDOM_LINES; i++) begin
         sx   = $urandom_range(0, COORD_MAX);
         sy   = $urandom_range(0, COORD_MAX);
         ex   = $urandom_range(0, COORD_MAX);
         ey   = $urandom_range(0, COORD_MAX);
         mode = $urandom_range(0, 19);
         case (mode)
            8, 9, 10: begin
               // short line near the start point
               ex = clamp_coord(sx + $urandom_range(0, 8) - 4);
               ey = clamp_coord(sy + $urandom_range(0, 8) - 4);
            end
            11, 12: begin
               ex = sx;
            end
            13, 14: begin
               ey = sy;
            end
            15, 16: begin
               // exact diagonal in a random direction
               dxs   = $urandom_range(0, 1) ? 1 : -1;
               dys   = $urandom_range(0, 1) ? 1 : -1;
               reach = (dxs > 0) ? COORD_MAX - sx : sx;
               if (((dys > 0) ? COORD_MAX - sy : sy) < reach)
                  reach = (dys > 0) ? COORD_MAX - sy : sy;
               reach = $urandom_range(0, reach);
               ex    = sx + dxs * reach;
               ey    = sy + dys * reach;
            end
            17: begin
               ex = sx;
               ey = sy;
            end
            18, 19: begin
               // endpoints pinned to the tile edges
               if ($urandom_range(0, 2) != 0) sx = $urandom_range(0, 1) ? COORD_MAX : 0;
               if ($urandom_range(0, 2) != 0) sy = $urandom_range(0, 1) ? COORD_MAX : 0;
               if ($urandom_range(0, 2) != 0) ex = $urandom_range(0, 1) ? COORD_MAX : 0;
               if ($urandom_range(0, 2) != 0) ey = $urandom_range(0, 1) ? COORD_MAX : 0;
            end
            default: begin
            end
         endcase

         // back-to-back stretches, fully random gaps, and sparse gaps
         phase = (i / 40) % 3;
         if (phase == 0)
            gap = 0;
         else if (phase == 1)
            gap = $urandom_range(0, 15);
         else
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;

         if ($urandom_range(0, 49) == 0)
            wait_for_drain();
         send_line(line_cmd(sx, sy, ex, ey), gap);
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
